### rtl/jcse_pkg.sv
// Package for the JPEG comment segment extractor.
// Holds the parser phase enum, status codes, marker constants and the result beat type.
// No dependencies.
package jcse_pkg;

  typedef enum logic [2:0] {
    PH_START0  = 3'd0,
    PH_START1  = 3'd1,
    PH_HUNT    = 3'd2,
    PH_MARKER  = 3'd3,
    PH_LENHI   = 3'd4,
    PH_LENLO   = 3'd5,
    PH_PAYLOAD = 3'd6,
    PH_DONE    = 3'd7
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BADSTART = 2'd1,
    ST_BADLEN   = 2'd2,
    ST_TRUNC    = 2'd3
  } status_t;

  localparam logic [7:0] MRK_PREFIX = 8'hFF;
  localparam logic [7:0] MRK_SOI    = 8'hD8;
  localparam logic [7:0] MRK_COM    = 8'hFE;
  localparam logic [7:0] MRK_EOI    = 8'hD9;
  localparam logic [7:0] MRK_SOS    = 8'hDA;
  localparam logic [7:0] BYTE_NUL   = 8'h00;

  localparam logic [15:0] LEN_HDR = 16'd2;

  // Result queue geometry.
  localparam int OQ_DEPTH = 4;
  localparam int OQ_AW    = $clog2(OQ_DEPTH);
  localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);

  typedef struct packed {
    logic [7:0] comment_byte;
    logic       is_status;
    logic [1:0] status;
  } result_t;

endpackage

### rtl/jcse_if.sv
// Channel interfaces for the JPEG comment segment extractor.
// Depends on nothing; the input channel carries file bytes, the output channel result beats.
interface jcse_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_file;

  modport source (output valid, output data_byte, output end_of_file, input ready);
  modport sink   (input valid, input data_byte, input end_of_file, output ready);
endinterface

interface jcse_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] comment_byte;
  logic       is_status;
  logic [1:0] status;

  modport source (output valid, output comment_byte, output is_status, output status,
                  input ready);
  modport sink   (input valid, input comment_byte, input is_status, input status,
                  output ready);
endinterface

### rtl/jpeg_comment_segment_extractor_unit.sv
// Top level of the JPEG comment segment extractor: marker parser and result queue.
// Depends on jcse_pkg and the channel interfaces in jcse_if.sv.
//
//   channel   dir  payload                          beat
//   in_bus    in   data_byte, end_of_file           one file byte
//   out_bus   out  comment_byte, is_status, status  one comment byte or final status
//
// One byte is taken per cycle while in_bus.ready is high; the parser state updates at
// the accepting edge and its results (at most a comment byte and a status beat) enter a
// four-entry result queue. A result beat is visible the cycle after its byte is taken.
// in_bus.ready is high while the queue has two free slots; with a consumer that takes
// one beat per cycle the queue never holds more than two beats, so the input never stalls.
// Reset (synchronous, active low) returns the parser to the start-of-file phase and
// empties the queue.
module jpeg_comment_segment_extractor_unit
  import jcse_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  jcse_in_if.sink     in_bus,
  jcse_out_if.source  out_bus
);

  phase_t      phase_r,       phase_nxt;
  logic [15:0] bytes_left_r,  bytes_left_nxt;
  logic [7:0]  length_high_r, length_high_nxt;
  logic        in_comment_r,  in_comment_nxt;
  logic        nul_seen_r,    nul_seen_nxt;

  result_t          oq_r [OQ_DEPTH];
  logic [OQ_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [OQ_CW-1:0] count_r;

  logic        c_vld, s_vld;
  status_t     s_code;
  logic [7:0]  b;
  logic [15:0] seg_len;
  logic        accept, pop;
  result_t     c_item, s_item;
  logic [OQ_CW-1:0] push_n;
  logic [OQ_AW-1:0] s_ptr;

  assign b       = in_bus.data_byte;
  assign seg_len = {length_high_r, b};

  always_comb begin
    phase_nxt       = phase_r;
    bytes_left_nxt  = bytes_left_r;
    length_high_nxt = length_high_r;
    in_comment_nxt  = in_comment_r;
    nul_seen_nxt    = nul_seen_r;
    c_vld           = 1'b0;
    s_vld           = 1'b0;
    s_code          = ST_OK;

    case (phase_r)
      PH_START0: begin
        if (b != MRK_PREFIX) begin
          s_vld = 1'b1; s_code = ST_BADSTART; phase_nxt = PH_DONE;
        end else begin
          phase_nxt = PH_START1;
        end
      end
      PH_START1: begin
        if (b != MRK_SOI) begin
          s_vld = 1'b1; s_code = ST_BADSTART; phase_nxt = PH_DONE;
        end else begin
          phase_nxt = PH_HUNT;
        end
      end
      PH_HUNT: begin
        if (b == MRK_PREFIX) phase_nxt = PH_MARKER;
      end
      PH_MARKER: begin
        // Fill bytes of 0xFF keep us waiting for the marker code.
        if (b == MRK_EOI || b == MRK_SOS) begin
          s_vld = 1'b1; s_code = ST_OK; phase_nxt = PH_DONE;
        end else if (b != MRK_PREFIX) begin
          in_comment_nxt = (b == MRK_COM);
          nul_seen_nxt   = 1'b0;
          phase_nxt      = PH_LENHI;
        end
      end
      PH_LENHI: begin
        length_high_nxt = b;
        phase_nxt       = PH_LENLO;
      end
      PH_LENLO: begin
        if (seg_len < LEN_HDR) begin
          s_vld = 1'b1; s_code = ST_BADLEN; phase_nxt = PH_DONE;
        end else if (seg_len == LEN_HDR) begin
          in_comment_nxt = 1'b0;
          phase_nxt      = PH_HUNT;
        end else begin
          bytes_left_nxt = seg_len - LEN_HDR;
          phase_nxt      = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        if (in_comment_r && !nul_seen_r) begin
          if (b == BYTE_NUL) nul_seen_nxt = 1'b1;
          else               c_vld        = 1'b1;
        end
        bytes_left_nxt = bytes_left_r - 16'd1;
        if (bytes_left_nxt == 16'd0) begin
          in_comment_nxt = 1'b0;
          nul_seen_nxt   = 1'b0;
          phase_nxt      = PH_HUNT;
        end
      end
      PH_DONE: begin
      end
      default: begin
        phase_nxt = PH_DONE;
      end
    endcase

    // The last byte of a file closes any parse still open and restarts the parser.
    if (in_bus.end_of_file) begin
      if (phase_nxt != PH_DONE) begin
        s_vld = 1'b1;
        if (phase_nxt == PH_START0 || phase_nxt == PH_START1) begin
          s_code = ST_BADSTART;
        end else if (phase_nxt == PH_PAYLOAD && in_comment_nxt && bytes_left_nxt != 16'd0) begin
          s_code = ST_TRUNC;
        end else begin
          s_code = ST_OK;
        end
      end
      phase_nxt       = PH_START0;
      bytes_left_nxt  = 16'd0;
      length_high_nxt = 8'd0;
      in_comment_nxt  = 1'b0;
      nul_seen_nxt    = 1'b0;
    end
  end

  assign in_bus.ready = (count_r <= OQ_CW'(OQ_DEPTH - 2));
  assign accept       = in_bus.valid && in_bus.ready;
  assign pop          = out_bus.valid && out_bus.ready;

  assign c_item = '{comment_byte: b, is_status: 1'b0, status: ST_OK};
  assign s_item = '{comment_byte: 8'd0, is_status: 1'b1, status: s_code};

  assign push_n = accept ? (OQ_CW'(c_vld) + OQ_CW'(s_vld)) : '0;
  assign s_ptr  = c_vld ? wr_ptr_r + OQ_AW'(1) : wr_ptr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_START0;
      bytes_left_r  <= 16'd0;
      length_high_r <= 8'd0;
      in_comment_r  <= 1'b0;
      nul_seen_r    <= 1'b0;
    end else if (accept) begin
      phase_r       <= phase_nxt;
      bytes_left_r  <= bytes_left_nxt;
      length_high_r <= length_high_nxt;
      in_comment_r  <= in_comment_nxt;
      nul_seen_r    <= nul_seen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + push_n[OQ_AW-1:0];
      if (pop) rd_ptr_r <= rd_ptr_r + OQ_AW'(1);
      count_r <= count_r + push_n - OQ_CW'(pop);
    end
  end

  // Queue entries are payload only; occupancy is tracked by count_r.
  always_ff @(posedge clk) begin
    if (accept && c_vld) oq_r[wr_ptr_r] <= c_item;
    if (accept && s_vld) oq_r[s_ptr]    <= s_item;
  end

  assign out_bus.valid        = (count_r != '0);
  assign out_bus.comment_byte = oq_r[rd_ptr_r].comment_byte;
  assign out_bus.is_status    = oq_r[rd_ptr_r].is_status;
  assign out_bus.status       = oq_r[rd_ptr_r].status;

endmodule

### verif/tb_jpeg_comment_segment_extractor_unit.sv
// Self-checking testbench for jpeg_comment_segment_extractor_unit: JPEG byte streams in,
// comment bytes and final status beats out, compared against an in-bench parser model.
// Depends on jcse_pkg and the channel interfaces in rtl/jcse_if.sv.
module tb_jpeg_comment_segment_extractor_unit
  import jcse_pkg::*;
();

  localparam int STREAM_BYTES = 1680;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 20;

  typedef struct packed {
    logic [7:0] data;
    logic       eof;
  } file_byte_t;

  logic clk;
  logic rst_n;

  jcse_in_if  in_bus ();
  jcse_out_if out_bus ();

  jpeg_comment_segment_extractor_unit DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_bus (in_bus),
    .out_bus(out_bus)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  file_byte_t file_bytes_q[$];
  logic [7:0] file_q[$];
  result_t    predicted_beats[$];

  int total_items;
  int accepted_cnt;
  int mismatches;
  int cycles;
  int send_gap_pct;
  int recv_stall_pct;

  // Parser model state.
  phase_t      parse_phase;
  logic [15:0] payload_left;
  logic [7:0]  seg_len_hi;
  bit          in_com;
  bit          nul_found;
  bit          parse_done;

  function automatic void restart_parse();
    parse_phase  = PH_START0;
    payload_left = '0;
    seg_len_hi   = '0;
    in_com       = 1'b0;
    nul_found    = 1'b0;
    parse_done   = 1'b0;
  endfunction

  function automatic void add_beat(logic [7:0] cbyte, logic is_st, status_t st);
    result_t r;
    r.comment_byte = cbyte;
    r.is_status    = is_st;
    r.status       = st;
    predicted_beats.push_back(r);
  endfunction

  function automatic void end_parse(status_t st);
    parse_done  = 1'b1;
    parse_phase = PH_DONE;
    add_beat(BYTE_NUL, 1'b1, st);
  endfunction

  // Advances the parser model by one file byte and queues the beats it produces.
  function automatic void parse_file_byte(logic [7:0] b, logic eof);
    logic [15:0] seg_len;
    status_t     st;
    if (!parse_done) begin
      case (parse_phase)
        PH_START0: begin
          if (b != MRK_PREFIX) end_parse(ST_BADSTART);
          else parse_phase = PH_START1;
        end
        PH_START1: begin
          if (b != MRK_SOI) end_parse(ST_BADSTART);
          else parse_phase = PH_HUNT;
        end
        PH_HUNT: begin
          if (b == MRK_PREFIX) parse_phase = PH_MARKER;
        end
        PH_MARKER: begin
          if (b == MRK_EOI || b == MRK_SOS) begin
            end_parse(ST_OK);
          end else if (b != MRK_PREFIX) begin
            in_com      = (b == MRK_COM);
            nul_found   = 1'b0;
            parse_phase = PH_LENHI;
          end
        end
        PH_LENHI: begin
          seg_len_hi  = b;
          parse_phase = PH_LENLO;
        end
        PH_LENLO: begin
          seg_len = {seg_len_hi, b};
          if (seg_len < LEN_HDR) begin
            end_parse(ST_BADLEN);
          end else if (seg_len == LEN_HDR) begin
            in_com      = 1'b0;
            parse_phase = PH_HUNT;
          end else begin
            payload_left = seg_len - LEN_HDR;
            parse_phase  = PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          if (in_com && !nul_found) begin
            if (b == BYTE_NUL) nul_found = 1'b1;
            else add_beat(b, 1'b0, ST_OK);
          end
          payload_left = payload_left - 16'd1;
          if (payload_left == 16'd0) begin
            in_com      = 1'b0;
            nul_found   = 1'b0;
            parse_phase = PH_HUNT;
          end
        end
        default: begin
          parse_done  = 1'b1;
          parse_phase = PH_DONE;
        end
      endcase
    end
    if (eof) begin
      if (!parse_done) begin
        st = ST_OK;
        if (parse_phase == PH_START0 || parse_phase == PH_START1) st = ST_BADSTART;
        else if (parse_phase == PH_PAYLOAD && in_com && payload_left != 16'd0) st = ST_TRUNC;
        end_parse(st);
      end
      restart_parse();
    end
  endfunction

  // Moves the file under construction into the stream, flagging its last byte.
  task automatic flush_file();
    file_byte_t fb;
    for (int i = 0; i < file_q.size(); i++) begin
      fb.data = file_q[i];
      fb.eof  = (i == file_q.size() - 1);
      file_bytes_q.push_back(fb);
    end
    file_q.delete();
  endtask

  // Bytes sit right-aligned in seq, first byte most significant.
  task automatic put_seq(input logic [8*16-1:0] seq, input int n);
    for (int i = 0; i < n; i++) file_q.push_back(seq[8*(n-1-i) +: 8]);
    flush_file();
  endtask

  function automatic logic [7:0] rand_payload_byte();
    if ($urandom_range(99) < 15) return BYTE_NUL;
    return 8'($urandom_range(255));
  endfunction

  function automatic logic [7:0] pick_marker();
    int r;
    r = $urandom_range(99);
    if (r < 50) return MRK_COM;
    if (r < 58) return MRK_SOI;
    if (r < 66) return 8'($urandom_range(8'hD0, 8'hD7));
    if (r < 72) return BYTE_NUL;
    if (r < 80) return 8'($urandom_range(255));
    return 8'($urandom_range(8'hC0, 8'hEF));
  endfunction

  // Mostly well-formed files with random segments; some noise and broken starts.
  task automatic gen_file();
    int          kind;
    int          r;
    int          nseg;
    int          pay;
    int          cut;
    bit          stop;
    logic [15:0] seg_len;
    kind = $urandom_range(99);
    if (kind < 6) begin
      repeat ($urandom_range(1, 10)) file_q.push_back(8'($urandom_range(255)));
    end else if (kind < 12) begin
      file_q.push_back(MRK_PREFIX);
      file_q.push_back(8'($urandom_range(255)));
      repeat ($urandom_range(0, 3)) file_q.push_back(8'($urandom_range(255)));
    end else begin
      file_q.push_back(MRK_PREFIX);
      file_q.push_back(MRK_SOI);
      nseg = $urandom_range(0, 4);
      stop = 1'b0;
      for (int s = 0; s < nseg && !stop; s++) begin
        if ($urandom_range(99) < 15)
          repeat ($urandom_range(1, 3)) file_q.push_back(8'($urandom_range(255)));
        file_q.push_back(MRK_PREFIX);
        if ($urandom_range(99) < 20)
          repeat ($urandom_range(1, 2)) file_q.push_back(MRK_PREFIX);
        file_q.push_back(pick_marker());
        r = $urandom_range(99);
        if (r < 5) begin
          seg_len = 16'($urandom_range(0, 1));
        end else if (r < 12) begin
          // A segment of random, usually large length: the file mostly ends inside its payload.
          seg_len = 16'($urandom_range(65535));
          stop    = 1'b1;
        end else begin
          seg_len = 16'($urandom_range(2, 12));
        end
        file_q.push_back(seg_len[15:8]);
        file_q.push_back(seg_len[7:0]);
        if (stop) pay = $urandom_range(0, 8);
        else pay = (seg_len > LEN_HDR) ? int'(seg_len - LEN_HDR) : 0;
        repeat (pay) file_q.push_back(rand_payload_byte());
      end
      if (!stop) begin
        r = $urandom_range(99);
        if (r < 45) begin
          file_q.push_back(MRK_PREFIX);
          file_q.push_back(MRK_EOI);
        end else if (r < 65) begin
          file_q.push_back(MRK_PREFIX);
          file_q.push_back(MRK_SOS);
        end
        repeat ($urandom_range(0, 3)) file_q.push_back(8'($urandom_range(255)));
      end
      if ($urandom_range(99) < 15) begin
        cut = $urandom_range(1, file_q.size());
        while (file_q.size() > cut) file_q.delete(file_q.size() - 1);
      end
    end
    flush_file();
  endtask

  always @* begin
    case ((accepted_cnt * 3) / ((total_items > 0) ? total_items : 1))
      0: begin
        send_gap_pct   = 7;
        recv_stall_pct = 61;
      end
      1: begin
        send_gap_pct   = 61;
        recv_stall_pct = 7;
      end
      default: begin
        send_gap_pct   = 0;
        recv_stall_pct = 0;
      end
    endcase
  end

  // Driver: offers the next file byte, predicts results for each accepted beat.
  always @(posedge clk) begin
    file_byte_t fb;
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        parse_file_byte(in_bus.data_byte, in_bus.end_of_file);
        accepted_cnt <= accepted_cnt + 1;
      end
      if (!in_bus.valid || in_bus.ready) begin
        if (file_bytes_q.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
          fb = file_bytes_q.pop_front();
          in_bus.valid       <= 1'b1;
          in_bus.data_byte   <= fb.data;
          in_bus.end_of_file <= fb.eof;
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: random backpressure, each accepted beat checked against the oldest prediction.
  always @(posedge clk) begin
    result_t exp_beat;
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        if (predicted_beats.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected beat: byte %h is_status %b status %0d",
                     out_bus.comment_byte, out_bus.is_status, out_bus.status);
        end else begin
          exp_beat = predicted_beats.pop_front();
          if (out_bus.comment_byte !== exp_beat.comment_byte ||
              out_bus.is_status !== exp_beat.is_status ||
              out_bus.status !== exp_beat.status) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected byte %h is_status %b status %0d, got %h %b %0d",
                       exp_beat.comment_byte, exp_beat.is_status, exp_beat.status,
                       out_bus.comment_byte, out_bus.is_status, out_bus.status);
          end
        end
      end
      out_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[jpeg_comment_segment_extractor_unit] ERROR");
      $finish;
    end
  end

  initial begin
    rst_n              = 1'b0;
    in_bus.valid       = 1'b0;
    in_bus.data_byte   = '0;
    in_bus.end_of_file = 1'b0;
    out_bus.ready      = 1'b0;
    accepted_cnt       = 0;
    mismatches         = 0;
    cycles             = 0;
    total_items        = 0;
    restart_parse();

    // Bad first byte, file ending right after the first 0xFF, then a bad second byte
    // followed by a byte that must be ignored.
    put_seq({8'h00}, 1);
    put_seq({8'hFF}, 1);
    put_seq({8'hFF, 8'h12, 8'h34}, 3);
    // Segment length below two.
    put_seq({8'hFF, 8'hD8, 8'hFF, 8'hC0, 8'h00, 8'h01}, 6);
    // Last byte completes a comment: a comment beat and the status beat from one byte.
    put_seq({8'hFF, 8'hD8, 8'hFF, 8'hFE, 8'h00, 8'h03, 8'h7F}, 7);
    // File ends inside a comment after a NUL.
    put_seq({8'hFF, 8'hD8, 8'hFF, 8'hFE, 8'h00, 8'h05, 8'h80, 8'h00}, 8);

    while (file_bytes_q.size() < STREAM_BYTES) gen_file();
    total_items = file_bytes_q.size();

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    while (accepted_cnt != total_items) @(posedge clk);
    while (predicted_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && predicted_beats.size() == 0) begin
      $display("[jpeg_comment_segment_extractor_unit] OK");
    end else begin
      $display("[jpeg_comment_segment_extractor_unit] ERROR");
    end
    $finish;
  end

endmodule
